>>> sv/ols_pkg.sv
// Shared types and codes for the ordered list store.
// Holds the command kinds, status codes and sequencer encodings.
// No dependencies.
`timescale 1ns / 1ps

package ols_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned STATUS_W = 3;

  // Command kinds carried by a request.
  typedef enum logic [KIND_W-1:0] {
    K_INS_HEAD        = 4'd0,
    K_INS_TAIL        = 4'd1,
    K_INS_POS         = 4'd2,
    K_INS_AFTER_FIRST = 4'd3,
    K_INS_AFTER_ALL   = 4'd4,
    K_DEL_HEAD        = 4'd5,
    K_DEL_TAIL        = 4'd6,
    K_DEL_POS         = 4'd7,
    K_DEL_FIRST       = 4'd8,
    K_DEL_ALL         = 4'd9,
    K_FIND_FIRST      = 4'd10,
    K_FIND_ALL        = 4'd11,
    K_COUNT           = 4'd12,
    K_DUMP            = 4'd13
  } kind_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_EVAL2 = 5'b01000,
    S_PUT   = 5'b10000
  } state_e;

  // What the sequencer does with each entry it reads.
  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_EMIT    = 2'd1,
    PH_EXPAND  = 2'd2,
    PH_COMPACT = 2'd3
  } phase_e;

endpackage

>>> sv/ols_store.sv
// Entry memory of the ordered list store with its shared compare unit.
// One write port, one read port with registered read data.
// Depends on ols_pkg.
`timescale 1ns / 1ps

module ols_store
  import ols_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [VALUE_W-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  input  logic [VALUE_W-1:0]         key_i,
  output logic [VALUE_W-1:0]         rd_data_o,
  output logic                       match_o
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // The one comparator, shared by every command that matches values.
  assign rd_data_o = rd_data_q;
  assign match_o   = (rd_data_q == key_i);

endmodule

>>> sv/ordered_list_store.sv
// Top level of the ordered list store: command sequencer, fill count and result register.
// Depends on ols_pkg and ols_store.
`timescale 1ns / 1ps

// Usage:
// A request is taken at a rising edge where start is high and busy is low. The
// kind selects an insert, a delete, a search, a count or a dump of the stored
// sequence; positions are one-based. Each result appears on the result ports
// for exactly one cycle with valid_o high, and last_o marks the final result
// of a request. The receiver cannot stall; results are never held back.
// Count, unused kinds and requests refused before any lookup finish straight
// from idle without a memory read. Every entry that is scanned, moved or dumped
// passes through a memory read and then an evaluate or write, because all of
// them go through the single memory port pair and the one shared comparator.
// Insert after all writes one extra copy for each match, and find all scans
// twice. Each result of find all and dump needs a fresh memory read first.
// busy stays high until the last result has been launched.
// Reset empties the store at once; no clearing pass is needed since only
// occupied entries are ever read.
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [KIND_W-1:0]          kind_i,
  input  logic signed [VALUE_W-1:0]  item_value_i,
  input  logic signed [VALUE_W-1:0]  added_value_i,
  input  logic [POS_W-1:0]           position_i,
  output logic                       valid_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [POS_W-1:0]           found_position_o,
  output logic signed [VALUE_W-1:0]  entry_value_o,
  output logic [POS_W-1:0]           entry_count_o,
  output logic                       last_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Sequencer state.
  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  kind_e               kind_q, kind_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [VALUE_W-1:0]  nval_q, nval_d;
  logic [IW-1:0]       s_q, s_d;
  logic [IW-1:0]       w_q, w_d;
  logic [IW-1:0]       stop_q, stop_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [IW-1:0]       f_q, f_d;
  logic                found_q, found_d;
  logic                all_q, all_d;
  logic [CW-1:0]       m_q, m_d;
  logic [CW-1:0]       nc_q, nc_d;
  logic [CW-1:0]       rpos_q, rpos_d;
  logic                hit_q, hit_d;
  logic [CW-1:0]       fill_q, fill_d;

  // Result register.
  logic                vld_q, vld_d;
  status_e             st_q, st_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [VALUE_W-1:0]  ev_q, ev_d;
  logic                last_q, last_d;

  // Memory port signals.
  logic                we;
  logic [IW-1:0]       wa;
  logic [VALUE_W-1:0]  wd;
  logic [VALUE_W-1:0]  rdata;
  logic                match;

  // Derived values of the current fill count and request.
  logic [CW-1:0]       depth_c;
  logic                full;
  logic [IW-1:0]       last_idx;
  logic [PW-1:0]       pos_x, fill_x;
  logic                bad_ins_pos, bad_del_pos;
  logic [POS_W-1:0]    pos_m1;
  logic [CW-1:0]       m_n;
  logic [IW-1:0]       f_n;
  logic                over;

  // Command helpers decided in the sequencer.
  logic                do_ins, do_del, do_fin, fin_upd, fin_hit;
  status_e             fin_st;
  logic [CW-1:0]       fin_pos, fin_nc;
  logic [IW-1:0]       ins_idx, del_idx;

  ols_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (we),
    .wr_addr_i (wa),
    .wr_data_i (wd),
    .rd_addr_i (s_q),
    .key_i     (val_q),
    .rd_data_o (rdata),
    .match_o   (match)
  );

  assign depth_c     = CW'(DEPTH);
  assign full        = (fill_q == depth_c);
  assign last_idx    = IW'(fill_q - CW'(1));
  assign pos_x       = PW'(position_i);
  assign fill_x      = PW'(fill_q);
  assign bad_ins_pos = (position_i == '0) || (pos_x > fill_x + PW'(1));
  assign bad_del_pos = (position_i == '0) || (pos_x > fill_x);
  assign pos_m1      = position_i - POS_W'(1);
  assign m_n         = m_q + CW'(match);
  assign f_n         = found_q ? f_q : s_q;
  assign over        = ({1'b0, fill_q} + {1'b0, m_n}) > {1'b0, depth_c};

  // Sequencer: decides each request, then walks the memory one entry at a time.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    kind_d  = kind_q;
    val_d   = val_q;
    nval_d  = nval_q;
    s_d     = s_q;
    w_d     = w_q;
    stop_d  = stop_q;
    idx_d   = idx_q;
    f_d     = f_q;
    found_d = found_q;
    all_d   = all_q;
    m_d     = m_q;
    nc_d    = nc_q;
    rpos_d  = rpos_q;
    hit_d   = hit_q;
    fill_d  = fill_q;
    vld_d   = 1'b0;
    st_d    = st_q;
    pos_d   = pos_q;
    ev_d    = ev_q;
    last_d  = last_q;
    we      = 1'b0;
    wa      = w_q;
    wd      = rdata;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    do_fin  = 1'b0;
    fin_upd = 1'b0;
    fin_hit = 1'b0;
    fin_st  = ST_OK;
    fin_pos = '0;
    fin_nc  = fill_q;
    ins_idx = '0;
    del_idx = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d  = kind_e'(kind_i);
          val_d   = item_value_i;
          nval_d  = added_value_i;
          s_d     = '0;
          m_d     = '0;
          f_d     = '0;
          found_d = 1'b0;
          rpos_d  = '0;
          hit_d   = 1'b0;
          unique case (kind_e'(kind_i))
            K_INS_HEAD: begin
              if (full) begin
                do_fin = 1'b1;
                fin_st = ST_FULL;
              end else begin
                do_ins  = 1'b1;
                ins_idx = '0;
              end
            end
            K_INS_TAIL: begin
              if (full) begin
                do_fin = 1'b1;
                fin_st = ST_FULL;
              end else begin
                do_ins  = 1'b1;
                ins_idx = IW'(fill_q);
              end
            end
            K_INS_POS: begin
              if (bad_ins_pos) begin
                do_fin = 1'b1;
                fin_st = ST_BAD_POS;
              end else if (full) begin
                do_fin = 1'b1;
                fin_st = ST_FULL;
              end else begin
                do_ins  = 1'b1;
                ins_idx = IW'(pos_m1);
              end
            end
            K_INS_AFTER_FIRST, K_INS_AFTER_ALL, K_FIND_FIRST, K_FIND_ALL: begin
              if (fill_q == '0) begin
                do_fin = 1'b1;
                fin_st = ST_NOT_FOUND;
              end else begin
                phase_d = PH_SCAN;
                state_d = S_READ;
              end
            end
            K_DEL_HEAD, K_DEL_TAIL: begin
              if (fill_q <= CW'(1)) begin
                do_fin = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                do_del  = 1'b1;
                del_idx = (kind_e'(kind_i) == K_DEL_HEAD) ? '0 : last_idx;
              end
            end
            K_DEL_POS: begin
              if (fill_q == '0) begin
                do_fin = 1'b1;
                fin_st = ST_EMPTY;
              end else if (bad_del_pos) begin
                do_fin = 1'b1;
                fin_st = ST_BAD_POS;
              end else if (fill_q == CW'(1)) begin
                do_fin = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                do_del  = 1'b1;
                del_idx = IW'(pos_m1);
              end
            end
            K_DEL_FIRST, K_DEL_ALL: begin
              if (fill_q == '0) begin
                do_fin = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                phase_d = PH_SCAN;
                state_d = S_READ;
              end
            end
            K_DUMP: begin
              if (fill_q == '0) begin
                do_fin = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                phase_d = PH_EMIT;
                state_d = S_READ;
              end
            end
            default: begin
              // Count and the unused kinds just report the fill count.
              do_fin = 1'b1;
              fin_st = ST_OK;
            end
          endcase
        end
      end

      S_READ: begin
        // The read address is s_q; data is registered for the next cycle.
        state_d = S_EVAL;
      end

      S_EVAL: begin
        unique case (phase_q)
          PH_SCAN: begin
            m_d     = m_n;
            f_d     = f_n;
            found_d = found_q | match;
            if (s_q == last_idx) begin
              if (m_n == '0) begin
                do_fin = 1'b1;
                fin_st = ST_NOT_FOUND;
              end else begin
                unique case (kind_q)
                  K_INS_AFTER_FIRST: begin
                    fin_pos = CW'(f_n) + CW'(1);
                    fin_hit = 1'b1;
                    if (full) begin
                      do_fin = 1'b1;
                      fin_st = ST_FULL;
                    end else begin
                      do_ins  = 1'b1;
                      ins_idx = f_n + IW'(1);
                    end
                  end
                  K_INS_AFTER_ALL: begin
                    if (over) begin
                      do_fin = 1'b1;
                      fin_st = ST_FULL;
                    end else begin
                      phase_d = PH_EXPAND;
                      s_d     = last_idx;
                      w_d     = IW'(fill_q + m_n - CW'(1));
                      stop_d  = '0;
                      all_d   = 1'b1;
                      nc_d    = fill_q + m_n;
                      state_d = S_READ;
                    end
                  end
                  K_DEL_FIRST: begin
                    if (fill_q == CW'(1)) begin
                      do_fin = 1'b1;
                      fin_st = ST_EMPTY;
                    end else begin
                      fin_pos = CW'(f_n) + CW'(1);
                      fin_hit = 1'b1;
                      do_del  = 1'b1;
                      del_idx = f_n;
                    end
                  end
                  K_DEL_ALL: begin
                    if (m_n == fill_q) begin
                      do_fin = 1'b1;
                      fin_st = ST_EMPTY;
                    end else begin
                      phase_d = PH_COMPACT;
                      s_d     = '0;
                      w_d     = '0;
                      stop_d  = last_idx;
                      all_d   = 1'b1;
                      nc_d    = fill_q - m_n;
                      state_d = S_READ;
                    end
                  end
                  K_FIND_FIRST: begin
                    do_fin  = 1'b1;
                    fin_pos = CW'(f_n) + CW'(1);
                    fin_hit = 1'b1;
                  end
                  K_FIND_ALL: begin
                    // Second pass emits the matches, counting down to the last one.
                    phase_d = PH_EMIT;
                    s_d     = '0;
                    state_d = S_READ;
                  end
                  default: begin
                    do_fin = 1'b1;
                  end
                endcase
              end
            end else begin
              s_d     = s_q + IW'(1);
              state_d = S_READ;
            end
          end

          PH_EMIT: begin
            if ((kind_q == K_DUMP) || match) begin
              vld_d  = 1'b1;
              st_d   = ST_OK;
              pos_d  = CW'(s_q) + CW'(1);
              ev_d   = rdata;
              last_d = (kind_q == K_DUMP) ? (s_q == last_idx) : (m_q == CW'(1));
              m_d    = m_q - CW'(1);
            end
            if (vld_d && last_d) begin
              state_d = S_IDLE;
            end else begin
              s_d     = s_q + IW'(1);
              state_d = S_READ;
            end
          end

          PH_EXPAND: begin
            we  = 1'b1;
            w_d = w_q - IW'(1);
            if (all_q && match) begin
              // Copy goes above the match; the match itself moves next cycle.
              wd      = nval_q;
              state_d = S_EVAL2;
            end else if (s_q == stop_q) begin
              if (all_q) begin
                do_fin  = 1'b1;
                fin_upd = 1'b1;
                fin_nc  = nc_q;
                fin_pos = rpos_q;
                fin_hit = hit_q;
              end else begin
                state_d = S_PUT;
              end
            end else begin
              s_d     = s_q - IW'(1);
              state_d = S_READ;
            end
          end

          PH_COMPACT: begin
            if (!(all_q && match)) begin
              we  = 1'b1;
              w_d = w_q + IW'(1);
            end
            if (s_q == stop_q) begin
              do_fin  = 1'b1;
              fin_upd = 1'b1;
              fin_nc  = nc_q;
              fin_pos = rpos_q;
              fin_hit = hit_q;
            end else begin
              s_d     = s_q + IW'(1);
              state_d = S_READ;
            end
          end
        endcase
      end

      S_EVAL2: begin
        // Second write of a matched entry during insert after all.
        we  = 1'b1;
        w_d = w_q - IW'(1);
        if (s_q == stop_q) begin
          do_fin  = 1'b1;
          fin_upd = 1'b1;
          fin_nc  = nc_q;
          fin_pos = rpos_q;
          fin_hit = hit_q;
        end else begin
          s_d     = s_q - IW'(1);
          state_d = S_READ;
        end
      end

      S_PUT: begin
        // Place the new value in the gap opened by the shift, or directly at the tail.
        we      = 1'b1;
        wa      = idx_q;
        wd      = (kind_q == K_INS_AFTER_FIRST) ? nval_q : val_q;
        do_fin  = 1'b1;
        fin_upd = 1'b1;
        fin_nc  = nc_q;
        fin_pos = rpos_q;
        fin_hit = hit_q;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Insert: shift entries idx and above up by one, or place directly at the tail.
    if (do_ins) begin
      idx_d  = ins_idx;
      nc_d   = fill_q + CW'(1);
      rpos_d = fin_pos;
      hit_d  = fin_hit;
      if (CW'(ins_idx) == fill_q) begin
        state_d = S_PUT;
      end else begin
        phase_d = PH_EXPAND;
        s_d     = last_idx;
        w_d     = IW'(fill_q);
        stop_d  = ins_idx;
        all_d   = 1'b0;
        state_d = S_READ;
      end
    end

    // Delete: shift entries above idx down by one; the tail needs no move.
    if (do_del) begin
      nc_d   = fill_q - CW'(1);
      rpos_d = fin_pos;
      hit_d  = fin_hit;
      if (del_idx == last_idx) begin
        do_fin  = 1'b1;
        fin_upd = 1'b1;
        fin_nc  = fill_q - CW'(1);
      end else begin
        phase_d = PH_COMPACT;
        s_d     = del_idx + IW'(1);
        w_d     = del_idx;
        stop_d  = last_idx;
        all_d   = 1'b0;
        state_d = S_READ;
      end
    end

    // Final result of a request, for all but the results emitted by find all and dump.
    if (do_fin) begin
      vld_d   = 1'b1;
      st_d    = fin_st;
      pos_d   = fin_pos;
      ev_d    = fin_hit ? val_q : '0;
      last_d  = 1'b1;
      state_d = S_IDLE;
      if (fin_upd) begin
        fill_d = fin_nc;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      vld_q   <= vld_d;
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    kind_q  <= kind_d;
    val_q   <= val_d;
    nval_q  <= nval_d;
    s_q     <= s_d;
    w_q     <= w_d;
    stop_q  <= stop_d;
    idx_q   <= idx_d;
    f_q     <= f_d;
    found_q <= found_d;
    all_q   <= all_d;
    m_q     <= m_d;
    nc_q    <= nc_d;
    rpos_q  <= rpos_d;
    hit_q   <= hit_d;
    st_q    <= st_d;
    pos_q   <= pos_d;
    ev_q    <= ev_d;
    last_q  <= last_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign valid_o          = vld_q;
  assign status_o         = st_q;
  assign found_position_o = POS_W'(pos_q);
  assign entry_value_o    = ev_q;
  assign entry_count_o    = POS_W'(fill_q);
  assign last_o           = last_q;

endmodule
